// ----- rtl/smpq_pkg.sv -----
// Shared types and constants for the stable minimum-priority queue.
// No dependencies.
package smpq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_PEEK   = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP,
        OP_ROTATE
    } array_op_t;

    // controller -> datapath
    typedef struct packed {
        array_op_t  op;
        logic       out_load;
        logic       out_head;
        logic [1:0] out_status;
        logic       out_last;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [OCC_W-1:0] occupancy;
    } dp_status_t;

endpackage

// ----- rtl/smpq_datapath.sv -----
// Sorted shifting entry array, occupancy counter and result register.
// Depends on smpq_pkg.
module smpq_datapath
    import smpq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    input  logic signed [31:0] item_value,
    input  logic signed [31:0] item_priority,
    output dp_status_t         status,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_priority,
    output logic [1:0]         out_status,
    output logic               out_last
);

    logic signed [31:0] val_reg  [CAPACITY];
    logic signed [31:0] pri_reg  [CAPACITY];
    logic signed [31:0] val_next [CAPACITY];
    logic signed [31:0] pri_next [CAPACITY];
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAPACITY-1:0] keep;

    logic signed [31:0] out_value_reg, out_priority_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg;

    // keep[i]: entry i stays put on insert (valid and not later in order)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (OCC_W'(i) < occ_reg) && (pri_reg[i] <= item_priority);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            case (cmd.op)
                OP_INSERT: begin
                    if (!keep[i]) begin
                        if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                            val_next[i] = item_value;
                            pri_next[i] = item_priority;
                        end else begin
                            val_next[i] = val_reg[(i == 0) ? 0 : i - 1];
                            pri_next[i] = pri_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
                OP_POP: begin
                    if (i < CAPACITY - 1) begin
                        val_next[i] = val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                        pri_next[i] = pri_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
                OP_ROTATE: begin
                    // head wraps to the tail slot of the occupied range
                    if (OCC_W'(i + 1) == occ_reg) begin
                        val_next[i] = val_reg[0];
                        pri_next[i] = pri_reg[0];
                    end else if (i < CAPACITY - 1 && OCC_W'(i + 1) < occ_reg) begin
                        val_next[i] = val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                        pri_next[i] = pri_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        occ_next = occ_reg;
        case (cmd.op)
            OP_INSERT: occ_next = occ_reg + OCC_W'(1);
            OP_POP:    occ_next = occ_reg - OCC_W'(1);
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
        if (cmd.out_load) begin
            out_value_reg    <= cmd.out_head ? val_reg[0] : 32'sd0;
            out_priority_reg <= cmd.out_head ? pri_reg[0] : 32'sd0;
            out_status_reg   <= cmd.out_status;
            out_last_reg     <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign status.empty     = (occ_reg == '0);
    assign status.full      = (occ_reg == OCC_W'(CAPACITY));
    assign status.occupancy = occ_reg;

    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign out_status   = out_status_reg;
    assign out_last     = out_last_reg;

endmodule

// ----- rtl/smpq_ctrl.sv -----
// Command sequencer: handshakes, list walk and result valid.
// Depends on smpq_pkg.
module smpq_ctrl
    import smpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    state_t           state_reg, state_next;
    logic [OCC_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op         = OP_NONE;
        cmd.out_load   = 1'b0;
        cmd.out_head   = 1'b0;
        cmd.out_status = STAT_OK;
        cmd.out_last   = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    if (s_command == CMD_INSERT) begin
                        if (status.full) begin
                            cmd.out_status = STAT_FULL;
                        end else begin
                            cmd.op = OP_INSERT;
                        end
                    end else if (status.empty) begin
                        cmd.out_status = STAT_EMPTY;
                    end else begin
                        cmd.out_head = 1'b1;
                        unique case (s_command)
                            CMD_POP:  cmd.op = OP_POP;
                            CMD_LIST: begin
                                cmd.op       = OP_ROTATE;
                                cmd.out_last = (status.occupancy == OCC_W'(1));
                                if (status.occupancy != OCC_W'(1)) begin
                                    state_next = ST_LIST;
                                    cnt_next   = status.occupancy - OCC_W'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_LIST: begin
                // one entry per transfer; the rotation restores order at the end
                if (out_free) begin
                    cmd.op       = OP_ROTATE;
                    cmd.out_load = 1'b1;
                    cmd.out_head = 1'b1;
                    cmd.out_last = (cnt_reg == OCC_W'(1));
                    m_valid_next = 1'b1;
                    cnt_next     = cnt_reg - OCC_W'(1);
                    if (cnt_reg == OCC_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/stable_min_priority_queue_core.sv -----
// Top level of the stable minimum-priority queue: controller plus datapath.
// Depends on smpq_pkg, smpq_ctrl and smpq_datapath.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_command, s_item_value, s_item_priority
//  m_      | out       | m_valid / m_ready  | m_out_value, m_out_priority, m_status, m_last
//
// Insert, peek and pop each give a single result; a command is accepted whenever the
// result register is empty or being drained in that cycle.
// List of N entries gives N results, one per cycle unless m_ stalls, by rotating the sorted
// register array; no command is accepted until the final one is loaded.
// Synchronous active-low reset empties the queue; entries are not cleared.
// A stalled m_ channel holds the result register and blocks s_ready.
module stable_min_priority_queue_core
    import smpq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [31:0] s_item_value,
    input  logic signed [31:0] s_item_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_value,
    output logic signed [31:0] m_out_priority,
    output logic [1:0]         m_status,
    output logic               m_last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    smpq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    smpq_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .item_value    (s_item_value),
        .item_priority (s_item_priority),
        .status        (status),
        .out_value     (m_out_value),
        .out_priority  (m_out_priority),
        .out_status    (m_status),
        .out_last      (m_last)
    );

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_INSERT && status.full
        |=> m_valid && m_status == STAT_FULL && m_last && $stable(status.occupancy))
        else $error("insert into full queue not reported or not dropped");

    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command != CMD_INSERT && status.empty
        |=> m_valid && m_status == STAT_EMPTY && m_last)
        else $error("read of empty queue not reported");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK
        |-> m_last && m_out_value == 32'sd0 && m_out_priority == 32'sd0)
        else $error("error result carries data or is not last");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_POP && !status.empty
        |=> status.occupancy == $past(status.occupancy) - OCC_W'(1))
        else $error("pop did not remove one entry");

endmodule
